### rtl/vfcm_pkg.sv
// shared constants, types and face tables for the voxel face culling mesher
package vfcm_pkg;

	localparam int CHUNK_EDGE   = 32;
	localparam int COORD_W      = $clog2(CHUNK_EDGE);
	localparam int VERT_W       = COORD_W + 1;
	localparam int MAP_DEPTH    = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int ADDR_W       = 3 * COORD_W;
	localparam int NUM_FACES    = 6;
	localparam int FACE_W       = 3;
	localparam int VTX_PER_FACE = 6;
	localparam int NUM_PROBES   = NUM_FACES + 1;
	localparam int PROBE_W      = $clog2(NUM_PROBES);
	localparam int VTX_W        = $clog2(VTX_PER_FACE);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MESH = 1'b1;

	// probe codes: center first, then the six neighbors in face order
	localparam logic [PROBE_W-1:0] PROBE_CENTER = PROBE_W'(0);
	localparam logic [PROBE_W-1:0] PROBE_PX     = PROBE_W'(1);
	localparam logic [PROBE_W-1:0] PROBE_NX     = PROBE_W'(2);
	localparam logic [PROBE_W-1:0] PROBE_PY     = PROBE_W'(3);
	localparam logic [PROBE_W-1:0] PROBE_NY     = PROBE_W'(4);
	localparam logic [PROBE_W-1:0] PROBE_PZ     = PROBE_W'(5);
	localparam logic [PROBE_W-1:0] PROBE_NZ     = PROBE_W'(6);
	localparam logic [PROBE_W-1:0] PROBE_LAST   = PROBE_NZ;

	localparam logic [VTX_W-1:0] VTX_LAST = VTX_W'(VTX_PER_FACE - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PROBE  = 4'b0010,
		ST_SETTLE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	// per-axis offset in two's complement, range -1..1
	typedef struct packed {
		logic [1:0] dx;
		logic [1:0] dy;
		logic [1:0] dz;
	} offs_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic              wr_bit;
	} mem_req_t;

	// corner bits {x, y, z}
	typedef logic [2:0] corner_t;

	localparam corner_t CORNER_TAB [NUM_FACES][4] = '{
		'{3'b100, 3'b110, 3'b111, 3'b101},
		'{3'b000, 3'b001, 3'b011, 3'b010},
		'{3'b010, 3'b011, 3'b111, 3'b110},
		'{3'b000, 3'b100, 3'b101, 3'b001},
		'{3'b001, 3'b101, 3'b111, 3'b011},
		'{3'b000, 3'b010, 3'b110, 3'b100}
	};

	localparam logic [1:0] TRI_ORDER [VTX_PER_FACE] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

	function automatic offs_t probe_offset(input logic [PROBE_W-1:0] idx);
		offs_t o;
		o = '{dx: 2'b00, dy: 2'b00, dz: 2'b00};
		case (idx)
			PROBE_PX: o.dx = 2'b01;
			PROBE_NX: o.dx = 2'b11;
			PROBE_PY: o.dy = 2'b01;
			PROBE_NY: o.dy = 2'b11;
			PROBE_PZ: o.dz = 2'b01;
			PROBE_NZ: o.dz = 2'b11;
			default: o = '{dx: 2'b00, dy: 2'b00, dz: 2'b00};
		endcase
		return o;
	endfunction

	function automatic offs_t corner_offset(input logic [FACE_W-1:0] face,
		input logic [VTX_W-1:0] vtx);
		corner_t c;
		offs_t   o;
		c    = CORNER_TAB[face][TRI_ORDER[vtx]];
		o.dx = {1'b0, c[2]};
		o.dy = {1'b0, c[1]};
		o.dz = {1'b0, c[0]};
		return o;
	endfunction

endpackage

### rtl/voxel_face_culling_mesher.sv
// top level of the voxel face culling mesher
// a load transfer writes the bitmap and leaves the sequencer idle; the next item is taken in the following cycle
// a mesh transfer probes center and six neighbors, one bitmap read per cycle,
// so the first vertex is registered after the probe and settle states
// vertices follow one per cycle while out_stall is low, six per exposed face; in_stall
// holds off new items until the last vertex of a mesh item is registered
// arst_n clears the sequencer and output valid; the bitmap is not cleared
module voxel_face_culling_mesher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_x,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_y,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_z,
	input  logic                         is_solid,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_x,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_y,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_z,
	output logic [vfcm_pkg::FACE_W-1:0]  face_dir,
	output logic                         last_vertex
);

	vfcm_pkg::mem_req_t                 mem_req;
	logic                               mem_rd_data;
	logic [vfcm_pkg::COORD_W-1:0]       add_base_x, add_base_y, add_base_z;
	vfcm_pkg::offs_t                    add_offs;
	logic [vfcm_pkg::VERT_W-1:0]        sum_x, sum_y, sum_z;

	vfcm_map u_map (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	vfcm_adder u_adder (
		.base_x (add_base_x),
		.base_y (add_base_y),
		.base_z (add_base_z),
		.offs   (add_offs),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.sum_z  (sum_z)
	);

	vfcm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.vox_x       (vox_x),
		.vox_y       (vox_y),
		.vox_z       (vox_z),
		.is_solid    (is_solid),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.vert_z      (vert_z),
		.face_dir    (face_dir),
		.last_vertex (last_vertex),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.add_base_x  (add_base_x),
		.add_base_y  (add_base_y),
		.add_base_z  (add_base_z),
		.add_offs    (add_offs),
		.sum_x       (sum_x),
		.sum_y       (sum_y),
		.sum_z       (sum_z)
	);

endmodule

### rtl/vfcm_map.sv
// solid/air bitmap of the chunk, one write or one registered read per cycle
module vfcm_map (
	input  logic               clk,
	input  vfcm_pkg::mem_req_t req,
	output logic               rd_data
);

	logic mem [vfcm_pkg::MAP_DEPTH];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_bit;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/vfcm_adder.sv
// shared coordinate adder: neighbor addresses while probing, corners while emitting
module vfcm_adder (
	input  logic [vfcm_pkg::COORD_W-1:0] base_x,
	input  logic [vfcm_pkg::COORD_W-1:0] base_y,
	input  logic [vfcm_pkg::COORD_W-1:0] base_z,
	input  vfcm_pkg::offs_t              offs,
	output logic [vfcm_pkg::VERT_W-1:0]  sum_x,
	output logic [vfcm_pkg::VERT_W-1:0]  sum_y,
	output logic [vfcm_pkg::VERT_W-1:0]  sum_z
);

	localparam int EXT_W = vfcm_pkg::COORD_W - 1;

	assign sum_x = {1'b0, base_x} + {{EXT_W{offs.dx[1]}}, offs.dx};
	assign sum_y = {1'b0, base_y} + {{EXT_W{offs.dy[1]}}, offs.dy};
	assign sum_z = {1'b0, base_z} + {{EXT_W{offs.dz[1]}}, offs.dz};

endmodule

### rtl/vfcm_seq.sv
// sequencer: takes items, probes the bitmap, steps through exposed faces and vertices
module vfcm_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_x,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_y,
	input  logic [vfcm_pkg::COORD_W-1:0] vox_z,
	input  logic                         is_solid,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_x,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_y,
	output logic [vfcm_pkg::VERT_W-1:0]  vert_z,
	output logic [vfcm_pkg::FACE_W-1:0]  face_dir,
	output logic                         last_vertex,
	output vfcm_pkg::mem_req_t           mem_req,
	input  logic                         mem_rd_data,
	output logic [vfcm_pkg::COORD_W-1:0] add_base_x,
	output logic [vfcm_pkg::COORD_W-1:0] add_base_y,
	output logic [vfcm_pkg::COORD_W-1:0] add_base_z,
	output vfcm_pkg::offs_t              add_offs,
	input  logic [vfcm_pkg::VERT_W-1:0]  sum_x,
	input  logic [vfcm_pkg::VERT_W-1:0]  sum_y,
	input  logic [vfcm_pkg::VERT_W-1:0]  sum_z
);

	localparam int CW = vfcm_pkg::COORD_W;

	vfcm_pkg::state_t                   state_q;
	logic [CW-1:0]                      base_x_q, base_y_q, base_z_q;
	logic [vfcm_pkg::PROBE_W-1:0]       idx_q;
	logic [vfcm_pkg::VTX_W-1:0]         vtx_q;
	// bit 0: center solid, bits 1..6: face still to emit
	logic [vfcm_pkg::NUM_PROBES-1:0]    exp_q;
	logic                               rd_vld_s1;
	logic [vfcm_pkg::PROBE_W-1:0]       rd_tag_s1;
	logic                               rd_out_s1;
	logic                               out_valid_q;
	logic [vfcm_pkg::VERT_W-1:0]        vert_x_q, vert_y_q, vert_z_q;
	logic [vfcm_pkg::FACE_W-1:0]        face_dir_q;
	logic                               last_vertex_q;

	logic [vfcm_pkg::NUM_FACES-1:0]     live_mask;
	logic [vfcm_pkg::FACE_W-1:0]        face_cur;
	logic                               one_left;
	logic                               outside;
	logic                               in_take;
	logic                               out_load;

	always_comb begin
		live_mask = exp_q[0] ? exp_q[vfcm_pkg::NUM_PROBES-1:1] : '0;
		face_cur  = '0;
		// lowest pending face wins
		for (int i = vfcm_pkg::NUM_FACES - 1; i >= 0; i--) begin
			if (live_mask[i]) begin
				face_cur = vfcm_pkg::FACE_W'(i);
			end
		end
		one_left = (live_mask & (live_mask - vfcm_pkg::NUM_FACES'(1))) == '0;
		outside  = sum_x[CW] | sum_y[CW] | sum_z[CW];
		in_take  = in_valid && (state_q == vfcm_pkg::ST_IDLE);
		out_load = (state_q == vfcm_pkg::ST_EMIT) && (live_mask != '0) &&
			(!out_valid_q || !out_stall);
	end

	assign in_stall = (state_q != vfcm_pkg::ST_IDLE);

	assign add_base_x = base_x_q;
	assign add_base_y = base_y_q;
	assign add_base_z = base_z_q;

	always_comb begin
		if (state_q == vfcm_pkg::ST_PROBE) begin
			add_offs = vfcm_pkg::probe_offset(idx_q);
		end else begin
			add_offs = vfcm_pkg::corner_offset(face_cur, vtx_q);
		end
	end

	always_comb begin
		mem_req.wr_en  = in_take && (operation == vfcm_pkg::OP_LOAD);
		mem_req.rd_en  = (state_q == vfcm_pkg::ST_PROBE);
		mem_req.wr_bit = is_solid;
		if (mem_req.rd_en) begin
			mem_req.addr = {sum_z[CW-1:0], sum_y[CW-1:0], sum_x[CW-1:0]};
		end else begin
			mem_req.addr = {vox_z, vox_y, vox_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vfcm_pkg::ST_IDLE;
			idx_q       <= vfcm_pkg::PROBE_CENTER;
			vtx_q       <= '0;
			exp_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_tag_s1   <= vfcm_pkg::PROBE_CENTER;
			rd_out_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == vfcm_pkg::ST_PROBE);
			rd_tag_s1 <= idx_q;
			rd_out_s1 <= outside;
			if (rd_vld_s1) begin
				if (rd_tag_s1 == vfcm_pkg::PROBE_CENTER) begin
					exp_q[rd_tag_s1] <= mem_rd_data;
				end else begin
					// border neighbors count as air
					exp_q[rd_tag_s1] <= rd_out_s1 | ~mem_rd_data;
				end
			end
			out_valid_q <= out_load | (out_valid_q & out_stall);
			case (state_q)
				vfcm_pkg::ST_IDLE: begin
					if (in_take && (operation == vfcm_pkg::OP_MESH)) begin
						idx_q   <= vfcm_pkg::PROBE_CENTER;
						state_q <= vfcm_pkg::ST_PROBE;
					end
				end
				vfcm_pkg::ST_PROBE: begin
					if (idx_q == vfcm_pkg::PROBE_LAST) begin
						state_q <= vfcm_pkg::ST_SETTLE;
					end else begin
						idx_q <= idx_q + vfcm_pkg::PROBE_W'(1);
					end
				end
				vfcm_pkg::ST_SETTLE: begin
					vtx_q   <= '0;
					state_q <= vfcm_pkg::ST_EMIT;
				end
				vfcm_pkg::ST_EMIT: begin
					if (live_mask == '0) begin
						state_q <= vfcm_pkg::ST_IDLE;
					end else if (out_load) begin
						if (vtx_q == vfcm_pkg::VTX_LAST) begin
							vtx_q <= '0;
							exp_q[face_cur + vfcm_pkg::FACE_W'(1)] <= 1'b0;
							if (one_left) begin
								state_q <= vfcm_pkg::ST_IDLE;
							end
						end else begin
							vtx_q <= vtx_q + vfcm_pkg::VTX_W'(1);
						end
					end
				end
				default: begin
					state_q <= vfcm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && (operation == vfcm_pkg::OP_MESH)) begin
			base_x_q <= vox_x;
			base_y_q <= vox_y;
			base_z_q <= vox_z;
		end
		if (out_load) begin
			vert_x_q      <= sum_x;
			vert_y_q      <= sum_y;
			vert_z_q      <= sum_z;
			face_dir_q    <= face_cur;
			last_vertex_q <= (vtx_q == vfcm_pkg::VTX_LAST) && one_left;
		end
	end

	assign out_valid   = out_valid_q;
	assign vert_x      = vert_x_q;
	assign vert_y      = vert_y_q;
	assign vert_z      = vert_z_q;
	assign face_dir    = face_dir_q;
	assign last_vertex = last_vertex_q;

`ifndef SYNTHESIS
	a_rd_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == vfcm_pkg::ST_PROBE))
		else $error("read data arrived without a probe");

	a_emit_after_settle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == vfcm_pkg::ST_EMIT) |-> $past(state_q == vfcm_pkg::ST_SETTLE))
		else $error("emit entered before probing finished");

	a_face_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (vtx_q == vfcm_pkg::VTX_LAST)) |=>
		($countones(exp_q[vfcm_pkg::NUM_PROBES-1:1]) + 1 ==
		$countones($past(exp_q[vfcm_pkg::NUM_PROBES-1:1]))))
		else $error("finished face not retired");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !mem_req.rd_en)
		else $error("bitmap write during probe");
`endif

endmodule

### verif/testbench.sv
// self-checking testbench for the voxel face culling mesher
module testbench;

	localparam int NUM_ITEMS      = 230;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int REGION_SPAN    = 4;
	localparam int REGION_REUSE   = 10;
	localparam int SOLID_PCT      = 65;

	// outward normal of each face, in face order +X,-X,+Y,-Y,+Z,-Z
	localparam int FACE_NORMAL [vfcm_pkg::NUM_FACES][3] = '{
		'{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1}
	};

	// four corners of each face as {x, y, z} offsets
	localparam int FACE_CORNER [vfcm_pkg::NUM_FACES][4][3] = '{
		'{'{1, 0, 0}, '{1, 1, 0}, '{1, 1, 1}, '{1, 0, 1}},
		'{'{0, 0, 0}, '{0, 0, 1}, '{0, 1, 1}, '{0, 1, 0}},
		'{'{0, 1, 0}, '{0, 1, 1}, '{1, 1, 1}, '{1, 1, 0}},
		'{'{0, 0, 0}, '{1, 0, 0}, '{1, 0, 1}, '{0, 0, 1}},
		'{'{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}},
		'{'{0, 0, 0}, '{0, 1, 0}, '{1, 1, 0}, '{1, 0, 0}}
	};

	// two triangles per face
	localparam int TRI_CORNER [vfcm_pkg::VTX_PER_FACE] = '{0, 1, 2, 0, 2, 3};

	typedef struct packed {
		logic [vfcm_pkg::VERT_W-1:0] x;
		logic [vfcm_pkg::VERT_W-1:0] y;
		logic [vfcm_pkg::VERT_W-1:0] z;
		logic [vfcm_pkg::FACE_W-1:0] face;
		logic                        last;
	} vertex_t;

	class vertex_scoreboard;
		bit      solid_map [vfcm_pkg::MAP_DEPTH];
		vertex_t pending_vertices [$];
		int      mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function int addr_of(int x, int y, int z);
			return (z * vfcm_pkg::CHUNK_EDGE + y) * vfcm_pkg::CHUNK_EDGE + x;
		endfunction

		function bit solid_at(int x, int y, int z);
			if (x < 0 || y < 0 || z < 0 ||
				x >= vfcm_pkg::CHUNK_EDGE || y >= vfcm_pkg::CHUNK_EDGE ||
				z >= vfcm_pkg::CHUNK_EDGE)
				return 1'b0;
			return solid_map[addr_of(x, y, z)];
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", what);
		endfunction

		// predict the vertices caused by one accepted transfer
		function void accept_item(logic op, int x, int y, int z, logic solid);
			logic [vfcm_pkg::NUM_FACES-1:0] open_faces;
			int                             remaining;
			int                             c;
			vertex_t                        v;
			if (op == vfcm_pkg::OP_LOAD) begin
				solid_map[addr_of(x, y, z)] = solid;
				return;
			end
			if (!solid_at(x, y, z))
				return;
			for (int f = 0; f < vfcm_pkg::NUM_FACES; f++)
				open_faces[f] = !solid_at(x + FACE_NORMAL[f][0], y + FACE_NORMAL[f][1],
					z + FACE_NORMAL[f][2]);
			remaining = $countones(open_faces) * vfcm_pkg::VTX_PER_FACE;
			for (int f = 0; f < vfcm_pkg::NUM_FACES; f++) begin
				if (!open_faces[f])
					continue;
				for (int k = 0; k < vfcm_pkg::VTX_PER_FACE; k++) begin
					c = TRI_CORNER[k];
					v.x    = vfcm_pkg::VERT_W'(x + FACE_CORNER[f][c][0]);
					v.y    = vfcm_pkg::VERT_W'(y + FACE_CORNER[f][c][1]);
					v.z    = vfcm_pkg::VERT_W'(z + FACE_CORNER[f][c][2]);
					v.face = vfcm_pkg::FACE_W'(f);
					remaining--;
					v.last = (remaining == 0);
					pending_vertices.push_back(v);
				end
			end
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t want;
			if (pending_vertices.size() == 0) begin
				report($sformatf("unexpected vertex x=%0d y=%0d z=%0d face=%0d last=%0b",
					got.x, got.y, got.z, got.face, got.last));
				return;
			end
			want = pending_vertices.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
				got.face !== want.face || got.last !== want.last)
				report($sformatf({"vertex mismatch: expected x=%0d y=%0d z=%0d face=%0d ",
					"last=%0b, got x=%0d y=%0d z=%0d face=%0d last=%0b"},
					want.x, want.y, want.z, want.face, want.last,
					got.x, got.y, got.z, got.face, got.last));
		endfunction

		function void check_drained();
			if (pending_vertices.size() != 0)
				report($sformatf("%0d expected vertices never arrived",
					pending_vertices.size()));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic                          operation   = vfcm_pkg::OP_LOAD;
	logic [vfcm_pkg::COORD_W-1:0]  vox_x       = '0;
	logic [vfcm_pkg::COORD_W-1:0]  vox_y       = '0;
	logic [vfcm_pkg::COORD_W-1:0]  vox_z       = '0;
	logic                          is_solid    = 1'b0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [vfcm_pkg::VERT_W-1:0]   vert_x;
	logic [vfcm_pkg::VERT_W-1:0]   vert_y;
	logic [vfcm_pkg::VERT_W-1:0]   vert_z;
	logic [vfcm_pkg::FACE_W-1:0]   face_dir;
	logic                          last_vertex;

	vertex_scoreboard sb = new();
	bit               loaded [vfcm_pkg::MAP_DEPTH];
	int               items_sent = 0;
	int               idle_pct   = 0;
	int               stall_pct  = 0;
	bit               hold_go    = 1'b0;
	int               cycles     = 0;
	int               region_x, region_y, region_z;
	int               region_uses = 0;

	voxel_face_culling_mesher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.vox_x       (vox_x),
		.vox_y       (vox_y),
		.vox_z       (vox_z),
		.is_solid    (is_solid),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vert_x      (vert_x),
		.vert_y      (vert_y),
		.vert_z      (vert_z),
		.face_dir    (face_dir),
		.last_vertex (last_vertex)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= TIMEOUT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_vertex(vertex_t'{vert_x, vert_y, vert_z, face_dir, last_vertex});
	end

	// receiver: one long hold-off on request, random stalls otherwise
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
				hold_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic solid_roll();
		return $urandom_range(99) < SOLID_PCT;
	endfunction

	// region bases lean toward the chunk borders
	function automatic int pick_base();
		case ($urandom_range(2))
			0: return 0;
			1: return vfcm_pkg::CHUNK_EDGE - REGION_SPAN;
			default: return $urandom_range(vfcm_pkg::CHUNK_EDGE - REGION_SPAN - 1);
		endcase
	endfunction

	task automatic send_item(logic op, int x, int y, int z, logic solid);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		vox_x     <= vfcm_pkg::COORD_W'(x);
		vox_y     <= vfcm_pkg::COORD_W'(y);
		vox_z     <= vfcm_pkg::COORD_W'(z);
		is_solid  <= solid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.accept_item(op, x, y, z, solid);
		items_sent++;
	endtask

	task automatic load_voxel(int x, int y, int z, logic solid);
		loaded[vertex_scoreboard::addr_of(x, y, z)] = 1'b1;
		send_item(vfcm_pkg::OP_LOAD, x, y, z, solid);
	endtask

	// never mesh a voxel whose center or in-chunk neighbors were never written
	task automatic prepare_and_mesh(int x, int y, int z);
		int nx, ny, nz;
		for (int p = 0; p <= vfcm_pkg::NUM_FACES; p++) begin
			nx = x;
			ny = y;
			nz = z;
			if (p > 0) begin
				nx += FACE_NORMAL[p-1][0];
				ny += FACE_NORMAL[p-1][1];
				nz += FACE_NORMAL[p-1][2];
			end
			if (nx < 0 || ny < 0 || nz < 0 ||
				nx >= vfcm_pkg::CHUNK_EDGE || ny >= vfcm_pkg::CHUNK_EDGE ||
				nz >= vfcm_pkg::CHUNK_EDGE)
				continue;
			if (!loaded[vertex_scoreboard::addr_of(nx, ny, nz)])
				load_voxel(nx, ny, nz, solid_roll());
		end
		send_item(vfcm_pkg::OP_MESH, x, y, z, 1'($urandom_range(1)));
	endtask

	task automatic random_step();
		int pick;
		if (region_uses == 0) begin
			region_x    = pick_base();
			region_y    = pick_base();
			region_z    = pick_base();
			region_uses = REGION_REUSE;
		end
		region_uses--;
		pick = $urandom_range(99);
		if (pick < 15)
			load_voxel($urandom_range(vfcm_pkg::CHUNK_EDGE - 1),
				$urandom_range(vfcm_pkg::CHUNK_EDGE - 1),
				$urandom_range(vfcm_pkg::CHUNK_EDGE - 1), 1'($urandom_range(1)));
		else if (pick < 30)
			load_voxel(region_x + $urandom_range(REGION_SPAN - 1),
				region_y + $urandom_range(REGION_SPAN - 1),
				region_z + $urandom_range(REGION_SPAN - 1), solid_roll());
		else
			prepare_and_mesh(region_x + $urandom_range(REGION_SPAN - 1),
				region_y + $urandom_range(REGION_SPAN - 1),
				region_z + $urandom_range(REGION_SPAN - 1));
	endtask

	initial begin : stimulus
		int directed_count;
		int target;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner voxel with every face exposed
		load_voxel(0, 0, 0, 1'b1);
		load_voxel(1, 0, 0, 1'b0);
		load_voxel(0, 1, 0, 1'b0);
		load_voxel(0, 0, 1, 1'b0);
		prepare_and_mesh(0, 0, 0);
		// far corner, one face covered
		load_voxel(31, 31, 31, 1'b1);
		load_voxel(30, 31, 31, 1'b0);
		load_voxel(31, 30, 31, 1'b0);
		load_voxel(31, 31, 30, 1'b1);
		prepare_and_mesh(31, 31, 31);
		// fully hidden voxel
		load_voxel(5, 5, 5, 1'b1);
		for (int f = 0; f < vfcm_pkg::NUM_FACES; f++)
			load_voxel(5 + FACE_NORMAL[f][0], 5 + FACE_NORMAL[f][1], 5 + FACE_NORMAL[f][2],
				1'b1);
		prepare_and_mesh(5, 5, 5);
		// air voxel
		load_voxel(5, 5, 5, 1'b0);
		prepare_and_mesh(5, 5, 5);
		// single exposed face
		load_voxel(5, 5, 5, 1'b1);
		load_voxel(6, 5, 5, 1'b0);
		prepare_and_mesh(5, 5, 5);

		directed_count = items_sent;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
					hold_go   = 1'b1;
				end
				1: begin
					idle_pct  = 68;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 68;
				end
				default: begin
					idle_pct  = 20;
					stall_pct = 20;
				end
			endcase
			target = directed_count + (p + 1) * (NUM_ITEMS - directed_count) / 4;
			while (items_sent < target)
				random_step();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
